// File: src/ist_pkg.sv
`default_nettype none

package ist_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_COUNT_W     = $clog2(DEF_TABLE_DEPTH + 1);
    localparam int FIELD_W         = 32;
    localparam int KIND_W          = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY        = 3'd0,
        KIND_INSERT_POINT = 3'd1,
        KIND_INSERT_RANGE = 3'd2,
        KIND_ERASE        = 3'd3,
        KIND_CUT          = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_MARK,
        ST_CHECK,
        ST_REMOVE,
        ST_INS1,
        ST_INS2,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SEARCH,
        CELL_MARK,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rm_p;
        logic     rm_s;
        logic     rm_range;
        logic     sel2;
    } cell_cmd_t;

    typedef struct packed {
        logic le_a;
        logic le_b;
        logic gt;
        logic prefix;
    } cell_link_t;

    localparam cell_link_t LINK_LEFT_EDGE = '{le_a: 1'b1, le_b: 1'b1, gt: 1'b0, prefix: 1'b0};
    localparam cell_link_t LINK_RIGHT_EDGE = '{le_a: 1'b0, le_b: 1'b0, gt: 1'b0, prefix: 1'b0};

endpackage

`default_nettype wire

// File: src/ist_req_if.sv
`default_nettype none

interface ist_req_if;
    import ist_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] first_value;
    logic signed [FIELD_W-1:0] second_value;

    modport source (output valid, output kind, output first_value, output second_value,
                    input ready);
    modport sink (input valid, input kind, input first_value, input second_value,
                  output ready);
endinterface

`default_nettype wire

// File: src/ist_rsp_if.sv
`default_nettype none

interface ist_rsp_if #(
    parameter int COUNT_W = ist_pkg::DEF_COUNT_W
);
    import ist_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [FIELD_W-1:0] found_lower;
    logic signed [FIELD_W-1:0] found_upper;
    logic [COUNT_W-1:0]        interval_count;

    modport source (output valid, output status, output found_lower, output found_upper,
                    output interval_count, input ready);
    modport sink (input valid, input status, input found_lower, input found_upper,
                  input interval_count, output ready);
endinterface

`default_nettype wire

// File: src/interval_set_table.sv
// Channel | Modport       | Payload                                              | Direction
// req     | ist_req_if    | kind, first_value, second_value                      | in
// rsp     | ist_rsp_if    | status, found_lower, found_upper, interval_count     | out
//
// A query or a rejected operation passes through the idle, search, decide and finish steps, and
// an operation that finds the table full passes also through the mark and check steps. A change
// of the table adds one removal step for each entry removed, one per cycle as the cell row
// shifts left, and one insertion step for each entry inserted (0 to 2), one per cycle as the row
// shifts right. Reset clears the entry count and the control state; entry contents are not
// cleared. A finished result waits in the output register; a new transaction is accepted
// meanwhile, and the block stalls only when it finishes again before the earlier result is taken.
`default_nettype none

module interval_set_table #(
    parameter int TABLE_DEPTH = ist_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = ist_pkg::DEF_VALUE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    ist_req_if.sink     req,
    ist_rsp_if.source   rsp
);
    import ist_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TABLE_DEPTH + 3);
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = ~VMIN;
    localparam logic signed [VW-1:0] ONE  = VW'(1);

    state_t  state_reg;
    state_t  state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    kind_t                kind_reg;
    logic signed [VW-1:0] a_reg;
    logic signed [VW-1:0] b_reg;
    logic                 pa_ex_reg, sa_ex_reg, pb_ex_reg;
    logic signed [VW-1:0] pa_lo_reg, pa_hi_reg, sa_lo_reg, sa_hi_reg, pb_lo_reg, pb_hi_reg;
    logic                 rm_p_reg, rm_s_reg, rm_range_reg, en1_reg, en2_reg;
    logic                 ins1_reg, ins2_reg;
    logic signed [VW-1:0] a1_lo_reg, a1_hi_reg, a2_lo_reg, a2_hi_reg;
    status_t              status_reg;
    logic signed [FIELD_W-1:0] found_lo_reg, found_hi_reg;
    status_t              out_status_reg;
    logic signed [FIELD_W-1:0] out_lo_reg, out_hi_reg;
    logic [CW-1:0]        out_count_reg;

    cell_cmd_t            cmd;
    logic                 accept;
    logic                 out_free;
    logic signed [VW-1:0] in_a, in_b;

    cell_link_t           link_w [TABLE_DEPTH+2];
    logic signed [VW-1:0] lo_w   [TABLE_DEPTH+2];
    logic signed [VW-1:0] hi_w   [TABLE_DEPTH+2];
    logic                 mark_w [TABLE_DEPTH+2];
    logic                 pa_w   [TABLE_DEPTH];
    logic                 sa_w   [TABLE_DEPTH];
    logic                 pb_w   [TABLE_DEPTH];
    logic                 eq1_w  [TABLE_DEPTH];
    logic                 eq2_w  [TABLE_DEPTH];
    logic                 more_w [TABLE_DEPTH];

    logic                 pa_any, sa_any, pb_any, any_mark, more_any, dup1_any, dup2_any;
    logic signed [VW-1:0] pa_lo_m, pa_hi_m, sa_lo_m, sa_hi_m, pb_lo_m, pb_hi_m;

    logic                 d_hx, d_cb, d_left, d_right, d_change, d_found;
    logic                 d_rm_p, d_rm_s, d_rm_range, d_en1, d_en2;
    logic signed [VW-1:0] d_a1_lo, d_a1_hi, d_a2_lo, d_a2_hi, a_dec, a_inc;

    logic                 c_dup2, c_eff1, c_eff2, c_full;
    logic [SW-1:0]        c_removed, c_total;

    assign link_w[0]               = LINK_LEFT_EDGE;
    assign lo_w[0]                 = '0;
    assign hi_w[0]                 = '0;
    assign mark_w[0]               = 1'b0;
    assign link_w[TABLE_DEPTH+1]   = LINK_RIGHT_EDGE;
    assign lo_w[TABLE_DEPTH+1]     = '0;
    assign hi_w[TABLE_DEPTH+1]     = '0;
    assign mark_w[TABLE_DEPTH+1]   = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ist_cell #(
            .INDEX       (i),
            .TABLE_DEPTH (TABLE_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .key_a      (a_reg),
            .key_b      (b_reg),
            .add1_lo    (a1_lo_reg),
            .add1_hi    (a1_hi_reg),
            .add2_lo    (a2_lo_reg),
            .add2_hi    (a2_hi_reg),
            .left_link  (link_w[i]),
            .left_lo    (lo_w[i]),
            .left_hi    (hi_w[i]),
            .left_mark  (mark_w[i]),
            .right_link (link_w[i+2]),
            .right_lo   (lo_w[i+2]),
            .right_hi   (hi_w[i+2]),
            .right_mark (mark_w[i+2]),
            .link       (link_w[i+1]),
            .lo         (lo_w[i+1]),
            .hi         (hi_w[i+1]),
            .mark       (mark_w[i+1]),
            .pa         (pa_w[i]),
            .sa         (sa_w[i]),
            .pb         (pb_w[i]),
            .eq1        (eq1_w[i]),
            .eq2        (eq2_w[i]),
            .more       (more_w[i])
        );
    end

    always_comb
    begin
        pa_any   = 1'b0;
        sa_any   = 1'b0;
        pb_any   = 1'b0;
        any_mark = 1'b0;
        more_any = 1'b0;
        dup1_any = 1'b0;
        dup2_any = 1'b0;
        pa_lo_m  = '0;
        pa_hi_m  = '0;
        sa_lo_m  = '0;
        sa_hi_m  = '0;
        pb_lo_m  = '0;
        pb_hi_m  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pa_any   = pa_any | pa_w[i];
            sa_any   = sa_any | sa_w[i];
            pb_any   = pb_any | pb_w[i];
            any_mark = any_mark | mark_w[i+1];
            more_any = more_any | more_w[i];
            dup1_any = dup1_any | eq1_w[i];
            dup2_any = dup2_any | eq2_w[i];
            pa_lo_m  = pa_lo_m | (pa_w[i] ? lo_w[i+1] : '0);
            pa_hi_m  = pa_hi_m | (pa_w[i] ? hi_w[i+1] : '0);
            sa_lo_m  = sa_lo_m | (sa_w[i] ? lo_w[i+1] : '0);
            sa_hi_m  = sa_hi_m | (sa_w[i] ? hi_w[i+1] : '0);
            pb_lo_m  = pb_lo_m | (pb_w[i] ? lo_w[i+1] : '0);
            pb_hi_m  = pb_hi_m | (pb_w[i] ? hi_w[i+1] : '0);
        end
    end

    assign accept   = (state_reg == ST_IDLE) && req.valid;
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_a     = VW'(req.first_value);
    assign in_b     = VW'(req.second_value);
    assign a_dec    = a_reg - ONE;
    assign a_inc    = a_reg + ONE;

    always_comb
    begin
        d_hx       = pa_ex_reg && (pa_hi_reg >= a_reg);
        d_cb       = pb_ex_reg && (pb_hi_reg >= b_reg);
        d_left     = pa_ex_reg && (a_reg != VMIN) && (pa_hi_reg == a_dec);
        d_right    = sa_ex_reg && (a_reg != VMAX) && (sa_lo_reg == a_inc);
        d_change   = 1'b0;
        d_found    = 1'b0;
        d_rm_p     = 1'b0;
        d_rm_s     = 1'b0;
        d_rm_range = 1'b0;
        d_en1      = 1'b0;
        d_en2      = 1'b0;
        d_a1_lo    = a_reg;
        d_a1_hi    = a_reg;
        d_a2_lo    = a_reg;
        d_a2_hi    = a_reg;
        unique case (kind_reg)
            KIND_QUERY:
            begin
                d_found = d_hx;
            end
            KIND_INSERT_POINT:
            begin
                d_change = !d_hx;
                d_rm_p   = d_left;
                d_rm_s   = d_right;
                d_en1    = 1'b1;
                d_a1_lo  = d_left ? pa_lo_reg : a_reg;
                d_a1_hi  = d_right ? sa_hi_reg : a_reg;
            end
            KIND_INSERT_RANGE:
            begin
                d_change   = !(d_hx && d_cb && (pa_lo_reg == pb_lo_reg)
                               && (pa_hi_reg == pb_hi_reg));
                d_rm_range = 1'b1;
                d_en1      = 1'b1;
                d_a1_lo    = d_hx ? pa_lo_reg : a_reg;
                d_a1_hi    = d_cb ? pb_hi_reg : b_reg;
            end
            KIND_ERASE:
            begin
                d_change = d_hx;
                d_rm_p   = 1'b1;
                d_en1    = a_reg != pa_lo_reg;
                d_a1_lo  = pa_lo_reg;
                d_a1_hi  = a_dec;
                d_en2    = a_reg != pa_hi_reg;
                d_a2_lo  = a_inc;
                d_a2_hi  = pa_hi_reg;
            end
            KIND_CUT:
            begin
                d_change = d_hx;
                d_rm_p   = 1'b1;
                d_en1    = 1'b1;
                d_a1_lo  = pa_lo_reg;
                d_a1_hi  = a_reg;
                d_en2    = 1'b1;
                d_a2_lo  = a_reg;
                d_a2_hi  = pa_hi_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        c_dup2    = dup2_any || (en1_reg && (a1_lo_reg == a2_lo_reg) && (a1_hi_reg == a2_hi_reg));
        c_eff1    = en1_reg && !dup1_any;
        c_eff2    = en2_reg && !c_dup2;
        c_removed = rm_range_reg ? SW'(any_mark) : (SW'(rm_p_reg) + SW'(rm_s_reg));
        c_total   = SW'(count_reg) + SW'(c_eff1) + SW'(c_eff2) - c_removed;
        c_full    = c_total > SW'(TABLE_DEPTH);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
                state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = d_change ? ST_MARK : ST_FINISH;
            ST_MARK:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                priority if (c_full)
                    state_next = ST_FINISH;
                else if (any_mark)
                    state_next = ST_REMOVE;
                else if (c_eff1)
                    state_next = ST_INS1;
                else if (c_eff2)
                    state_next = ST_INS2;
                else
                    state_next = ST_FINISH;
            end
            ST_REMOVE:
            begin
                priority if (more_any)
                    state_next = ST_REMOVE;
                else if (ins1_reg)
                    state_next = ST_INS1;
                else if (ins2_reg)
                    state_next = ST_INS2;
                else
                    state_next = ST_FINISH;
            end
            ST_INS1:
                state_next = ins2_reg ? ST_INS2 : ST_FINISH;
            ST_INS2:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = CELL_HOLD;
        cmd.rm_p     = rm_p_reg;
        cmd.rm_s     = rm_s_reg;
        cmd.rm_range = rm_range_reg;
        cmd.sel2     = 1'b0;
        count_next   = count_reg;
        unique case (state_reg)
            ST_SEARCH:
                cmd.op = CELL_SEARCH;
            ST_MARK:
                cmd.op = CELL_MARK;
            ST_REMOVE:
            begin
                cmd.op     = CELL_REMOVE;
                count_next = count_reg - CW'(1);
            end
            ST_INS1:
            begin
                cmd.op     = CELL_INSERT;
                count_next = count_reg + CW'(1);
            end
            ST_INS2:
            begin
                cmd.op     = CELL_INSERT;
                cmd.sel2   = 1'b1;
                count_next = count_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_FINISH) && out_free)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    assign req.ready          = state_reg == ST_IDLE;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_lower    = out_lo_reg;
    assign rsp.found_upper    = out_hi_reg;
    assign rsp.interval_count = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_t'(req.kind);
            if ((kind_t'(req.kind) == KIND_INSERT_RANGE) && (in_a > in_b))
            begin
                a_reg <= in_b;
                b_reg <= in_a;
            end
            else
            begin
                a_reg <= in_a;
                b_reg <= in_b;
            end
        end
        if (state_reg == ST_SEARCH)
        begin
            pa_ex_reg <= pa_any;
            sa_ex_reg <= sa_any;
            pb_ex_reg <= pb_any;
            pa_lo_reg <= pa_lo_m;
            pa_hi_reg <= pa_hi_m;
            sa_lo_reg <= sa_lo_m;
            sa_hi_reg <= sa_hi_m;
            pb_lo_reg <= pb_lo_m;
            pb_hi_reg <= pb_hi_m;
        end
        if (state_reg == ST_DECIDE)
        begin
            rm_p_reg     <= d_rm_p;
            rm_s_reg     <= d_rm_s;
            rm_range_reg <= d_rm_range;
            en1_reg      <= d_en1;
            en2_reg      <= d_en2;
            a1_lo_reg    <= d_a1_lo;
            a1_hi_reg    <= d_a1_hi;
            a2_lo_reg    <= d_a2_lo;
            a2_hi_reg    <= d_a2_hi;
            status_reg   <= d_found ? STATUS_OK : STATUS_MISS;
            found_lo_reg <= d_found ? FIELD_W'(pa_lo_reg) : '0;
            found_hi_reg <= d_found ? FIELD_W'(pa_hi_reg) : '0;
        end
        if (state_reg == ST_CHECK)
        begin
            status_reg <= c_full ? STATUS_FULL : STATUS_OK;
            ins1_reg   <= c_eff1;
            ins2_reg   <= c_eff2;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_status_reg <= status_reg;
            out_lo_reg     <= found_lo_reg;
            out_hi_reg     <= found_hi_reg;
            out_count_reg  <= count_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_remove_has_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |-> any_mark)
        else $error("Removal step entered with no marked entry.");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("Result transaction raised outside the finishing step.");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS2) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("Insertion did not advance the entry count.");

endmodule

`default_nettype wire

// File: src/ist_cell.sv
`default_nettype none

module ist_cell #(
    parameter int INDEX       = 0,
    parameter int TABLE_DEPTH = ist_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = ist_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  ist_pkg::cell_cmd_t                   cmd,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
    input  logic signed [VALUE_WIDTH-1:0]        key_a,
    input  logic signed [VALUE_WIDTH-1:0]        key_b,
    input  logic signed [VALUE_WIDTH-1:0]        add1_lo,
    input  logic signed [VALUE_WIDTH-1:0]        add1_hi,
    input  logic signed [VALUE_WIDTH-1:0]        add2_lo,
    input  logic signed [VALUE_WIDTH-1:0]        add2_hi,
    input  ist_pkg::cell_link_t                  left_link,
    input  logic signed [VALUE_WIDTH-1:0]        left_lo,
    input  logic signed [VALUE_WIDTH-1:0]        left_hi,
    input  logic                                 left_mark,
    input  ist_pkg::cell_link_t                  right_link,
    input  logic signed [VALUE_WIDTH-1:0]        right_lo,
    input  logic signed [VALUE_WIDTH-1:0]        right_hi,
    input  logic                                 right_mark,
    output ist_pkg::cell_link_t                  link,
    output logic signed [VALUE_WIDTH-1:0]        lo,
    output logic signed [VALUE_WIDTH-1:0]        hi,
    output logic                                 mark,
    output logic                                 pa,
    output logic                                 sa,
    output logic                                 pb,
    output logic                                 eq1,
    output logic                                 eq2,
    output logic                                 more
);
    import ist_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [VALUE_WIDTH-1:0] lo_reg;
    logic signed [VALUE_WIDTH-1:0] hi_reg;
    logic                          mark_reg;
    logic                          pa_reg;
    logic                          sa_reg;

    logic                          occ;
    logic                          le_a;
    logic                          le_b;
    logic                          gt;
    logic                          prefix;
    logic                          in_range;
    logic signed [VALUE_WIDTH-1:0] ins_lo;
    logic signed [VALUE_WIDTH-1:0] ins_hi;

    always_comb
    begin
        occ      = count > CW'(INDEX);
        ins_lo   = cmd.sel2 ? add2_lo : add1_lo;
        ins_hi   = cmd.sel2 ? add2_hi : add1_hi;
        le_a     = occ && (lo_reg <= key_a);
        le_b     = occ && (lo_reg <= key_b);
        gt       = !occ || (lo_reg > ins_lo) || ((lo_reg == ins_lo) && (hi_reg > ins_hi));
        prefix   = left_link.prefix || mark_reg;
        in_range = (lo_reg >= add1_lo) && (hi_reg <= add1_hi);

        link.le_a   = le_a;
        link.le_b   = le_b;
        link.gt     = gt;
        link.prefix = prefix;

        pa   = le_a && !right_link.le_a;
        sa   = occ && !le_a && left_link.le_a;
        pb   = le_b && !right_link.le_b;
        eq1  = occ && !mark_reg && (lo_reg == add1_lo) && (hi_reg == add1_hi);
        eq2  = occ && !mark_reg && (lo_reg == add2_lo) && (hi_reg == add2_hi);
        more = mark_reg && left_link.prefix;
    end

    assign lo   = lo_reg;
    assign hi   = hi_reg;
    assign mark = mark_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CELL_SEARCH:
            begin
                pa_reg <= pa;
                sa_reg <= sa;
            end
            CELL_MARK:
            begin
                mark_reg <= occ && ((cmd.rm_p && pa_reg) || (cmd.rm_s && sa_reg)
                                    || (cmd.rm_range && in_range));
            end
            CELL_REMOVE:
            begin
                if (prefix)
                begin
                    lo_reg   <= right_lo;
                    hi_reg   <= right_hi;
                    mark_reg <= right_mark;
                end
            end
            CELL_INSERT:
            begin
                if (gt)
                begin
                    if (!left_link.gt)
                    begin
                        lo_reg   <= ins_lo;
                        hi_reg   <= ins_hi;
                        mark_reg <= 1'b0;
                    end
                    else
                    begin
                        lo_reg   <= left_lo;
                        hi_reg   <= left_hi;
                        mark_reg <= left_mark;
                    end
                end
            end
            CELL_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
